// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the vocoder peak phase lock RTL.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset
`define VPPL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition implies a property in the same cycle
`define VPPL_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies a property in the next cycle
`define VPPL_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/vppl_pkg.sv =====
// Package for the vocoder peak phase lock core: word types, codes, defaults.
// No dependencies.
package vppl_pkg;

    localparam int DEF_MAX_BINS   = 2048;
    localparam int DEF_PHASE_BITS = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [11:0] NUM_BINS_RESET    = 12'd2048;
    localparam logic [15:0] PITCH_RATIO_RESET = 16'd4096;
    localparam logic [31:0] MAG_FLOOR_RESET   = 32'd0;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_PEAK = 2'd1,
        KIND_READ = 2'd2
    } kind_e;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NUM_BINS    = 2'd0,
        REG_PITCH_RATIO = 2'd1,
        REG_MAG_FLOOR   = 2'd2
    } reg_index_e;

    typedef struct packed {
        logic [1:0]          kind;
        logic [10:0]         bin_index;
        logic signed [15:0]  analysis_phase;
        logic signed [15:0]  synthesis_phase;
        logic [31:0]         magnitude;
        logic [10:0]         source_peak;
        logic                last_peak;
    } cmd_t;

    typedef struct packed {
        logic [10:0]         read_bin;
        logic signed [15:0]  phase_out;
        logic                was_locked;
    } result_t;

    // Control of the shared adder
    typedef struct packed {
        logic sub;
    } alu_ctl_t;

endpackage

// ===== rtl/core/vppl_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module vppl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/vppl_alu.sv =====
// Shared adder/subtractor for the locking pass (midpoints and phase sums).
// Depends on vppl_pkg.
module vppl_alu #(
    parameter int WIDTH = 16
) (
    input  vppl_pkg::alu_ctl_t ctl,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic [WIDTH-1:0]   y
);
    import vppl_pkg::*;

    logic [WIDTH-1:0] b_op;

    // Invert operand for subtraction, carry in supplies the extra one
    always_comb
    begin
        b_op = ctl.sub ? ~b : b;
        y    = a + b_op + WIDTH'(ctl.sub);
    end

endmodule

// ===== rtl/core/vocoder_peak_phase_lock_core.sv =====
// Top level of the vocoder peak phase lock core: sequencer, stores, peak map.
// Depends on vppl_pkg, vppl_ram, vppl_alu and assert_macros.svh.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  command  | start, busy, cmd               | taken when start && !busy
//  result   | result_valid, result           | one-cycle strobe, no stall
//  config   | cfg_we, cfg_index, cfg_data    | written when cfg_we high
//
// Load words write when accepted; a read word holds busy in S_RSP and its
// result strobes from the result register after. A peak word passes S_PK_T,
// then S_PK_CHK for a new target. The last peak adds the locking pass: an
// owner fill per target and bin, then a walk of every bin, longer for a
// locked bin, through the single read port of the synthesis store.
// After reset the owner store is cleared in S_CLR with busy high.
`include "assert_macros.svh"
module vocoder_peak_phase_lock_core #(
    parameter int MAX_BINS   = vppl_pkg::DEF_MAX_BINS,
    parameter int PHASE_BITS = vppl_pkg::DEF_PHASE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  vppl_pkg::cmd_t                      cmd,
    output logic                                result_valid,
    output vppl_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [vppl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [vppl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import vppl_pkg::*;

    localparam int IW = $clog2(MAX_BINS);
    localparam int BW = IW + 1;
    localparam int AW = (BW > PHASE_BITS) ? BW : PHASE_BITS;
    localparam int SW = PHASE_BITS + 2;    // {locked, audible, phase}
    localparam int OW = IW + 1;            // {owned, owner}

    typedef enum logic [13:0] {
        S_CLR     = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_RSP     = 14'b00000000000100,
        S_PK_T    = 14'b00000000001000,
        S_PK_CHK  = 14'b00000000010000,
        S_PA_INIT = 14'b00000000100000,
        S_PA_CUR  = 14'b00000001000000,
        S_PA_LO   = 14'b00000010000000,
        S_PA_HI   = 14'b00000100000000,
        S_PA_FILL = 14'b00001000000000,
        S_PB_RD   = 14'b00010000000000,
        S_PB_OWN  = 14'b00100000000000,
        S_PB_DIFF = 14'b01000000000000,
        S_PB_WR   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0] num_bins_reg;
    logic [15:0] ratio_reg;
    logic [31:0] floor_reg;

    logic [26:0]         prod_reg;
    logic                last_reg;
    logic [IW-1:0]       t_reg;
    logic [IW-1:0]       prev_reg;
    logic                prev_valid_reg;
    logic [BW-1:0]       count_reg;
    logic [BW-1:0]       i_reg;
    logic [IW-1:0]       prv_reg, cur_reg, nxt_reg;
    logic [BW-1:0]       b_reg, hi_reg;
    logic [10:0]         rd_bin_reg;
    logic                rd_ok_reg;
    logic [SW-1:0]       syn_b_reg;
    logic [PHASE_BITS-1:0] ana_b_reg, syn_o_reg, diff_reg;
    result_t             res_reg;
    logic                res_valid_reg;

    // RAM ports
    logic                  ana_we, syn_we, own_we, tgt_we;
    logic [IW-1:0]         ana_wa, syn_wa, own_wa, tgt_wa;
    logic [IW-1:0]         ana_ra, syn_ra, own_ra, tgt_ra;
    logic [PHASE_BITS-1:0] ana_wd, ana_rd;
    logic [SW-1:0]         syn_wd, syn_rd;
    logic [OW-1:0]         own_wd, own_rd;
    logic [IW-1:0]         tgt_wd, tgt_rd;

    // Shared adder
    alu_ctl_t      alu_ctl;
    logic [AW-1:0] alu_a, alu_b, alu_y;

    // Derived values
    logic          accept;
    logic [BW-1:0] n_act, n_m1;
    logic [27:0]   rounded;
    logic [15:0]   t_raw;
    logic [IW-1:0] t_val;
    logic          bin_ok;
    logic [IW-1:0] bin_addr;
    logic [31:0]   ana_in32, syn_in32;
    logic [BW-1:0] mid;
    logic          tgt_take;
    logic [BW-1:0] count_new;
    logic          pass_fill;
    logic          fill_go;
    logic          last_tgt;
    logic          lock_go;
    logic          b_last;

    vppl_ram #(.WIDTH(PHASE_BITS), .DEPTH(MAX_BINS)) u_ana_ram (
        .clk(clk), .we(ana_we), .waddr(ana_wa), .wdata(ana_wd),
        .raddr(ana_ra), .rdata(ana_rd)
    );

    vppl_ram #(.WIDTH(SW), .DEPTH(MAX_BINS)) u_syn_ram (
        .clk(clk), .we(syn_we), .waddr(syn_wa), .wdata(syn_wd),
        .raddr(syn_ra), .rdata(syn_rd)
    );

    vppl_ram #(.WIDTH(OW), .DEPTH(MAX_BINS)) u_own_ram (
        .clk(clk), .we(own_we), .waddr(own_wa), .wdata(own_wd),
        .raddr(own_ra), .rdata(own_rd)
    );

    vppl_ram #(.WIDTH(IW), .DEPTH(MAX_BINS)) u_tgt_ram (
        .clk(clk), .we(tgt_we), .waddr(tgt_wa), .wdata(tgt_wd),
        .raddr(tgt_ra), .rdata(tgt_rd)
    );

    vppl_alu #(.WIDTH(AW)) u_alu (
        .ctl(alu_ctl), .a(alu_a), .b(alu_b), .y(alu_y)
    );

    // Decode the command word and the peak mapping
    always_comb
    begin
        accept    = start && (state_reg == S_IDLE);
        n_act     = (32'(num_bins_reg) > 32'(MAX_BINS)) ? BW'(MAX_BINS) : BW'(num_bins_reg);
        n_m1      = n_act - BW'(1);
        rounded   = 28'(prod_reg) + 28'd2048;
        t_raw     = rounded[27:12];
        t_val     = (32'(t_raw) > 32'(n_m1)) ? n_m1[IW-1:0] : IW'(t_raw);
        bin_ok    = 32'(cmd.bin_index) < 32'(MAX_BINS);
        bin_addr  = IW'(cmd.bin_index);
        ana_in32  = 32'(cmd.analysis_phase);
        syn_in32  = 32'(cmd.synthesis_phase);
        mid       = alu_y[BW-1:0] >> 1;
        tgt_take  = syn_rd[SW-2] && (count_reg < BW'(MAX_BINS));
        count_new = count_reg + BW'(tgt_take);
        pass_fill = (n_act != '0) && (count_reg != '0);
        fill_go   = (b_reg <= hi_reg) && (b_reg < n_act);
        last_tgt  = (i_reg + BW'(1)) == count_reg;
        lock_go   = own_rd[OW-1] && syn_rd[SW-2];
        b_last    = b_reg == BW'(MAX_BINS - 1);
    end

    // Steer the shared adder
    always_comb
    begin
        alu_ctl.sub = 1'b0;
        alu_a       = '0;
        alu_b       = '0;
        unique case (state_reg)
            S_PA_LO:
            begin
                alu_a = AW'(prv_reg);
                alu_b = AW'(cur_reg);
            end
            S_PA_HI:
            begin
                alu_a = AW'(cur_reg);
                alu_b = AW'(tgt_rd);
            end
            S_PB_DIFF:
            begin
                alu_ctl.sub = 1'b1;
                alu_a       = AW'(ana_b_reg);
                alu_b       = AW'(ana_rd);
            end
            S_PB_WR:
            begin
                alu_a = AW'(syn_o_reg);
                alu_b = AW'(diff_reg);
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // Drive the RAM ports
    always_comb
    begin
        ana_we = 1'b0;
        ana_wa = bin_addr;
        ana_wd = ana_in32[PHASE_BITS-1:0];
        ana_ra = IW'(b_reg);
        syn_we = 1'b0;
        syn_wa = bin_addr;
        syn_wd = {1'b0, cmd.magnitude > floor_reg, syn_in32[PHASE_BITS-1:0]};
        syn_ra = IW'(b_reg);
        own_we = 1'b0;
        own_wa = IW'(b_reg);
        own_wd = '0;
        own_ra = IW'(b_reg);
        tgt_we = 1'b0;
        tgt_wa = IW'(count_reg);
        tgt_wd = t_reg;
        tgt_ra = '0;
        unique case (state_reg)
            S_CLR:
            begin
                own_we = 1'b1;
            end
            S_IDLE:
            begin
                syn_ra = bin_addr;
                if (accept && cmd.kind == KIND_LOAD && bin_ok)
                begin
                    ana_we = 1'b1;
                    syn_we = 1'b1;
                end
            end
            S_PK_T:
            begin
                syn_ra = t_val;
            end
            S_PK_CHK:
            begin
                tgt_we = tgt_take;
            end
            S_PA_LO:
            begin
                tgt_ra = IW'(i_reg + BW'(1));
            end
            S_PA_FILL:
            begin
                own_we = fill_go;
                own_wd = {1'b1, cur_reg};
            end
            S_PB_OWN:
            begin
                own_we = 1'b1;
                syn_ra = own_rd[IW-1:0];
                ana_ra = own_rd[IW-1:0];
                syn_wa = IW'(b_reg);
                syn_wd = {1'b0, syn_rd[SW-2], syn_rd[PHASE_BITS-1:0]};
                syn_we = !lock_go;
            end
            S_PB_WR:
            begin
                syn_we = 1'b1;
                syn_wa = IW'(b_reg);
                syn_wd = {1'b1, syn_b_reg[SW-2], alu_y[PHASE_BITS-1:0]};
            end
            default:
            begin
                tgt_ra = '0;
            end
        endcase
    end

    // Sequence the words and the locking pass
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (b_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && cmd.kind == KIND_READ)
                begin
                    state_next = S_RSP;
                end
                else if (accept && cmd.kind == KIND_PEAK)
                begin
                    state_next = S_PK_T;
                end
            end
            S_RSP:
            begin
                state_next = S_IDLE;
            end
            S_PK_T:
            begin
                if (n_act != '0 && !(prev_valid_reg && t_val == prev_reg))
                begin
                    state_next = S_PK_CHK;
                end
                else if (last_reg)
                begin
                    state_next = pass_fill ? S_PA_INIT : S_PB_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PK_CHK:
            begin
                if (last_reg)
                begin
                    state_next = (count_new != '0) ? S_PA_INIT : S_PB_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PA_INIT: state_next = S_PA_CUR;
            S_PA_CUR:  state_next = S_PA_LO;
            S_PA_LO:   state_next = S_PA_HI;
            S_PA_HI:   state_next = S_PA_FILL;
            S_PA_FILL:
            begin
                if (!fill_go)
                begin
                    state_next = last_tgt ? S_PB_RD : S_PA_LO;
                end
            end
            S_PB_RD:   state_next = S_PB_OWN;
            S_PB_OWN:
            begin
                if (lock_go)
                begin
                    state_next = S_PB_DIFF;
                end
                else
                begin
                    state_next = b_last ? S_IDLE : S_PB_RD;
                end
            end
            S_PB_DIFF: state_next = S_PB_WR;
            S_PB_WR:   state_next = b_last ? S_IDLE : S_PB_RD;
            default:   state_next = S_IDLE;
        endcase
    end

    // Hold control state, counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            num_bins_reg   <= NUM_BINS_RESET;
            ratio_reg      <= PITCH_RATIO_RESET;
            floor_reg      <= MAG_FLOOR_RESET;
            count_reg      <= '0;
            prev_valid_reg <= 1'b0;
            b_reg          <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= (state_reg == S_RSP);

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NUM_BINS:    num_bins_reg <= cfg_data[11:0];
                    REG_PITCH_RATIO: ratio_reg    <= cfg_data[15:0];
                    REG_MAG_FLOOR:   floor_reg    <= cfg_data;
                    default:         num_bins_reg <= num_bins_reg;
                endcase
            end

            unique case (state_reg)
                S_CLR:
                begin
                    b_reg <= b_last ? '0 : b_reg + BW'(1);
                end
                S_PK_T:
                begin
                    b_reg <= '0;
                end
                S_PK_CHK:
                begin
                    b_reg <= '0;
                    if (tgt_take)
                    begin
                        count_reg      <= count_new;
                        prev_valid_reg <= 1'b1;
                    end
                end
                S_PA_LO:
                begin
                    b_reg <= (i_reg == '0) ? '0 : mid + BW'(1);
                end
                S_PA_FILL:
                begin
                    b_reg <= fill_go ? b_reg + BW'(1) : '0;
                end
                S_PB_OWN:
                begin
                    if (!lock_go)
                    begin
                        if (b_last)
                        begin
                            b_reg          <= '0;
                            count_reg      <= '0;
                            prev_valid_reg <= 1'b0;
                        end
                        else
                        begin
                            b_reg <= b_reg + BW'(1);
                        end
                    end
                end
                S_PB_WR:
                begin
                    if (b_last)
                    begin
                        b_reg          <= '0;
                        count_reg      <= '0;
                        prev_valid_reg <= 1'b0;
                    end
                    else
                    begin
                        b_reg <= b_reg + BW'(1);
                    end
                end
                default:
                begin
                    b_reg <= b_reg;
                end
            endcase
        end
    end

    // Hold payload registers of the peak map, pass and read response
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg   <= 27'(cmd.source_peak) * 27'(ratio_reg);
            last_reg   <= cmd.last_peak;
            rd_bin_reg <= cmd.bin_index;
            rd_ok_reg  <= bin_ok;
        end
        if (state_reg == S_PK_T)
        begin
            t_reg <= t_val;
        end
        if (state_reg == S_PK_CHK && tgt_take)
        begin
            prev_reg <= t_reg;
        end
        if (state_reg == S_PA_CUR)
        begin
            cur_reg <= tgt_rd;
            i_reg   <= '0;
        end
        if (state_reg == S_PA_HI)
        begin
            nxt_reg <= tgt_rd;
            hi_reg  <= last_tgt ? n_m1 : mid;
        end
        if (state_reg == S_PA_FILL && !fill_go)
        begin
            prv_reg <= cur_reg;
            cur_reg <= nxt_reg;
            i_reg   <= i_reg + BW'(1);
        end
        if (state_reg == S_PB_OWN)
        begin
            syn_b_reg <= syn_rd;
            ana_b_reg <= ana_rd;
        end
        if (state_reg == S_PB_DIFF)
        begin
            syn_o_reg <= syn_rd[PHASE_BITS-1:0];
            diff_reg  <= alu_y[PHASE_BITS-1:0];
        end
        if (state_reg == S_RSP)
        begin
            res_reg.read_bin   <= rd_bin_reg;
            res_reg.phase_out  <= rd_ok_reg ? 16'(32'(syn_rd[PHASE_BITS-1:0])) : 16'd0;
            res_reg.was_locked <= rd_ok_reg && syn_rd[SW-1];
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Checks on the sequencer and stores
    `VPPL_ASSERT_IMP(a_read_strobes, accept && cmd.kind == KIND_READ, ##2 result_valid, "read word gave no result")
    `VPPL_ASSERT(a_count_bound, count_reg <= BW'(MAX_BINS), "target count beyond store depth")
    `VPPL_ASSERT_IMP(a_tgt_room, tgt_we, count_reg < BW'(MAX_BINS), "target write into full list")
    `VPPL_ASSERT_IMP(a_fill_range, state_reg == S_PA_FILL && own_we, b_reg < n_act, "owner fill beyond active bins")
    `VPPL_ASSERT_NXT(a_pass_done, state_reg == S_PB_WR && b_last, count_reg == '0 && !prev_valid_reg, "pass left targets behind")

endmodule
